[sv/ppsch_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; used by ppsch_cell and preemptive_priority_scheduler_core.
`default_nettype none
package ppsch_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int ID_W   = 8;
    localparam int TIME_W = 16;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_ADDED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RAN   = 2'd2;
    localparam logic [STAT_W-1:0] ST_IDLE  = 2'd3;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // best candidate so far, handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              running;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] arrival;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] left;
    } cand_t;

    // table update broadcast to the cells
    typedef struct packed {
        logic              add;
        logic              dec;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } upd_t;

endpackage
`default_nettype wire

[sv/ppsch_cell.sv]
// One process-table slot plus one stage of the selection chain.
// Depends on ppsch_pkg.
`default_nettype none
module ppsch_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire [ppsch_pkg::TIME_W-1:0] now,
    input  wire                        run_valid,
    input  wire [IDX_W-1:0]            run_slot,
    input  wire ppsch_pkg::upd_t       upd,
    input  wire [IDX_W-1:0]            upd_slot,
    input  wire ppsch_pkg::cand_t      cand_in,
    input  wire [IDX_W-1:0]            cand_slot_in,
    output ppsch_pkg::cand_t           cand_out,
    output logic [IDX_W-1:0]           cand_slot_out
);

    logic                          used_reg;
    logic [ppsch_pkg::ID_W-1:0]    id_reg;
    logic [ppsch_pkg::TIME_W-1:0]  arrival_reg;
    logic [ppsch_pkg::TIME_W-1:0]  burst_reg;
    logic [ppsch_pkg::TIME_W-1:0]  left_reg;
    logic [ppsch_pkg::PRIO_W-1:0]  prio_reg;
    ppsch_pkg::cand_t              cand_reg;
    ppsch_pkg::cand_t              cand_next;
    logic [IDX_W-1:0]              slot_reg;
    logic [IDX_W-1:0]              slot_next;
    logic                          hit;
    logic                          is_run;
    logic                          eligible;
    logic                          take_own;

    assign hit    = (upd_slot == IDX_W'(IDX));
    assign is_run = run_valid && (run_slot == IDX_W'(IDX));
    assign eligible = used_reg && (left_reg != '0) && (arrival_reg <= now);

    // incoming candidate comes from lower slots, so it wins a full tie
    always_comb
    begin
        take_own = eligible && (!cand_in.valid || (prio_reg < cand_in.prio) ||
                   ((prio_reg == cand_in.prio) && !cand_in.running &&
                    (is_run || (arrival_reg < cand_in.arrival))));
        if (take_own)
        begin
            cand_next.valid   = 1'b1;
            cand_next.running = is_run;
            cand_next.prio    = prio_reg;
            cand_next.arrival = arrival_reg;
            cand_next.id      = id_reg;
            cand_next.burst   = burst_reg;
            cand_next.left    = left_reg;
            slot_next         = IDX_W'(IDX);
        end
        else
        begin
            cand_next = cand_in;
            slot_next = cand_slot_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (upd.add && hit)
        begin
            used_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.add && hit)
        begin
            id_reg      <= upd.id;
            arrival_reg <= upd.arrival;
            burst_reg   <= upd.burst;
            left_reg    <= upd.burst;
            prio_reg    <= upd.prio;
        end
        else if (upd.dec && hit)
        begin
            left_reg <= left_reg - ppsch_pkg::TIME_W'(1);
        end
        cand_reg <= cand_next;
        slot_reg <= slot_next;
    end

    assign cand_out      = cand_reg;
    assign cand_slot_out = slot_reg;

endmodule
`default_nettype wire

[sv/preemptive_priority_scheduler_core.sv]
// Top level of the preemptive priority scheduler: control, clock and counters.
// Depends on ppsch_pkg and ppsch_cell.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one command item: cmd=0 adds a
//    process (proc_id, arrival, burst, prio) to the lowest free slot, cmd=1 is
//    one time tick. Output channel (out_valid / out_stall) returns exactly one
//    result item per command.
//  - Items are handled one at a time. An add goes from accept straight to the
//    execute step; a tick first passes the scan step, whose length is set by
//    the selection chain: the best candidate walks through the row of slot
//    cells, one cell per cycle, before the winner is known.
//  - in_stall is low whenever no command is in progress, so a new command is
//    taken while the previous result still sits in the output register.
//  - When the receiver holds out_stall, the result stays put and the command
//    in progress waits in its final step; table state is updated only when
//    its result is written to the output register.
//  - Reset (rst_n, async, active low) empties the table, clears the clock,
//    the counters and the running-process mark. Payload storage of a slot is
//    not cleared; it is only read after an add has written it.
`default_nettype none
module preemptive_priority_scheduler_core #(
    parameter int SLOTS = ppsch_pkg::SLOTS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire                          cmd,
    input  wire [ppsch_pkg::ID_W-1:0]    proc_id,
    input  wire [ppsch_pkg::TIME_W-1:0]  arrival,
    input  wire [ppsch_pkg::TIME_W-1:0]  burst,
    input  wire [ppsch_pkg::PRIO_W-1:0]  prio,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [ppsch_pkg::STAT_W-1:0] status,
    output logic [ppsch_pkg::ID_W-1:0]   run_id,
    output logic                         finished,
    output logic [ppsch_pkg::TIME_W-1:0] turnaround,
    output logic [ppsch_pkg::TIME_W-1:0] waiting,
    output logic [ppsch_pkg::TIME_W-1:0] now,
    output logic                         all_done
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int TW    = ppsch_pkg::TIME_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                scan_cnt_reg;

    // latched command
    logic                            cmd_reg;
    logic [ppsch_pkg::ID_W-1:0]      id_reg;
    logic [TW-1:0]                   arrival_reg;
    logic [TW-1:0]                   burst_reg;
    logic [ppsch_pkg::PRIO_W-1:0]    prio_reg;

    logic [TW-1:0]                   clock_reg;
    logic                            run_valid_reg;
    logic [IDX_W-1:0]                run_slot_reg;
    logic [CNT_W-1:0]                done_cnt_reg;
    logic [CNT_W-1:0]                used_cnt_reg;

    // output register
    logic                            out_valid_reg;
    logic [ppsch_pkg::STAT_W-1:0]    status_reg;
    logic [ppsch_pkg::ID_W-1:0]      run_id_reg;
    logic                            fin_reg;
    logic [TW-1:0]                   tat_reg;
    logic [TW-1:0]                   wt_reg;
    logic                            all_done_reg;

    // selection chain
    ppsch_pkg::cand_t                chain   [SLOTS+1];
    logic [IDX_W-1:0]                chain_slot [SLOTS+1];
    ppsch_pkg::upd_t                 upd;
    logic [IDX_W-1:0]                upd_slot;

    logic                            accept;
    logic                            out_free;
    logic                            commit;
    logic                            full;
    ppsch_pkg::cand_t                win;
    logic [TW-1:0]                   clock_inc;
    logic [TW-1:0]                   left_dec;
    logic [TW-1:0]                   tat_calc;
    logic [TW-1:0]                   wt_calc;
    logic [TW-1:0]                   burst_fix;
    logic                            done_now;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == S_EXEC) && out_free;
    assign full     = (used_cnt_reg == CNT_W'(SLOTS));
    assign win      = chain[SLOTS];

    assign chain[0]      = '0;
    assign chain_slot[0] = '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            ppsch_cell #(
                .IDX_W (IDX_W),
                .IDX   (g)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .now           (clock_reg),
                .run_valid     (run_valid_reg),
                .run_slot      (run_slot_reg),
                .upd           (upd),
                .upd_slot      (upd_slot),
                .cand_in       (chain[g]),
                .cand_slot_in  (chain_slot[g]),
                .cand_out      (chain[g+1]),
                .cand_slot_out (chain_slot[g+1])
            );
        end
    endgenerate

    // tick arithmetic on the winner; clock saturates
    always_comb
    begin
        clock_inc = (clock_reg == ppsch_pkg::TIME_MAX) ? clock_reg : clock_reg + TW'(1);
        left_dec  = win.left - TW'(1);
        done_now  = (left_dec == '0);
        tat_calc  = (clock_inc > win.arrival) ? clock_inc - win.arrival : '0;
        wt_calc   = (tat_calc > win.burst) ? tat_calc - win.burst : '0;
        burst_fix = (burst_reg == '0) ? TW'(1) : burst_reg;
    end

    // broadcast to the table, only on the committing cycle
    always_comb
    begin
        upd.add     = commit && (cmd_reg == ppsch_pkg::CMD_ADD) && !full;
        upd.dec     = commit && (cmd_reg == ppsch_pkg::CMD_TICK) && win.valid;
        upd.id      = id_reg;
        upd.arrival = arrival_reg;
        upd.burst   = burst_fix;
        upd.prio    = prio_reg;
        upd_slot    = (cmd_reg == ppsch_pkg::CMD_ADD) ? used_cnt_reg[IDX_W-1:0]
                                                      : chain_slot[SLOTS];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd == ppsch_pkg::CMD_ADD) ? S_EXEC : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            clock_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            done_cnt_reg  <= '0;
            used_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
            end
            else
            begin
                scan_cnt_reg <= '0;
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (upd.add)
            begin
                used_cnt_reg <= used_cnt_reg + CNT_W'(1);
            end

            if (commit && (cmd_reg == ppsch_pkg::CMD_TICK))
            begin
                clock_reg <= clock_inc;
                if (win.valid)
                begin
                    if (done_now)
                    begin
                        done_cnt_reg  <= done_cnt_reg + CNT_W'(1);
                        run_valid_reg <= 1'b0;
                        run_slot_reg  <= '0;
                    end
                    else
                    begin
                        run_valid_reg <= 1'b1;
                        run_slot_reg  <= chain_slot[SLOTS];
                    end
                end
            end
        end
    end

    // command latch and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd;
            id_reg      <= proc_id;
            arrival_reg <= arrival;
            burst_reg   <= burst;
            prio_reg    <= prio;
        end
        if (commit)
        begin
            run_id_reg <= '0;
            fin_reg    <= 1'b0;
            tat_reg    <= '0;
            wt_reg     <= '0;
            if (cmd_reg == ppsch_pkg::CMD_ADD)
            begin
                status_reg   <= full ? ppsch_pkg::ST_FULL : ppsch_pkg::ST_ADDED;
                all_done_reg <= full ? (done_cnt_reg == used_cnt_reg) : 1'b0;
            end
            else if (win.valid)
            begin
                status_reg   <= ppsch_pkg::ST_RAN;
                run_id_reg   <= win.id;
                fin_reg      <= done_now;
                tat_reg      <= done_now ? tat_calc : '0;
                wt_reg       <= done_now ? wt_calc : '0;
                all_done_reg <= done_now && ((done_cnt_reg + CNT_W'(1)) == used_cnt_reg);
            end
            else
            begin
                status_reg   <= ppsch_pkg::ST_IDLE;
                all_done_reg <= (done_cnt_reg == used_cnt_reg);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign run_id     = run_id_reg;
    assign finished   = fin_reg;
    assign turnaround = tat_reg;
    assign waiting    = wt_reg;
    assign now        = clock_reg;
    assign all_done   = all_done_reg;

    // completions never outnumber added processes
    a_done_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        done_cnt_reg <= used_cnt_reg)
        else $error("done count exceeds used count");

    // the running mark always points at a filled slot
    a_run_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> (CNT_W'(run_slot_reg) < used_cnt_reg))
        else $error("running slot beyond filled slots");

    // only a tick that ran a process can report completion
    a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fin_reg) |-> (status_reg == ppsch_pkg::ST_RAN))
        else $error("finished without a run");

    // the table is only touched while a command commits
    a_upd_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (upd.add || upd.dec) |=> out_valid_reg)
        else $error("table update without result");

endmodule
`default_nettype wire

[tb/preemptive_priority_scheduler_core_tb.sv]
// Self-checking testbench for preemptive_priority_scheduler_core: directed rows, random
// ticks and adds, then a short stretch of ticks with no idling. Depends on ppsch_pkg and
// the scheduler RTL only.
`timescale 1ns / 100ps
module preemptive_priority_scheduler_core_tb;

    localparam int N_SLOTS      = ppsch_pkg::SLOTS_DEF;
    localparam int RAND_ITEMS   = 800;
    localparam int LONG_HOLD    = 400;     // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 2 * (N_SLOTS + 2);
    localparam int RUN_LIMIT_NS = 10_000_000;

    typedef logic [ppsch_pkg::ID_W-1:0]   id_t;
    typedef logic [ppsch_pkg::TIME_W-1:0] time_t;
    typedef logic [ppsch_pkg::PRIO_W-1:0] prio_t;
    typedef logic [ppsch_pkg::STAT_W-1:0] stat_t;

    // one command item as offered on the input channel
    typedef struct packed {
        logic  cmd;
        id_t   id;
        time_t arrival;
        time_t burst;
        prio_t prio;
    } sched_cmd_t;

    // one result item as seen on the output channel
    typedef struct packed {
        stat_t             status;
        id_t               run_id;
        logic              finished;
        time_t             turnaround;
        time_t             waiting;
        time_t             now;
        logic              all_done;
    } sched_res_t;

    // directed row: command plus, where it is obvious, a hand-written result
    typedef struct packed {
        sched_cmd_t c;
        logic       fixed_exp;
        sched_res_t r;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                cmd;
    id_t                 proc_id;
    time_t               arrival;
    time_t               burst;
    prio_t               prio;
    logic                out_valid;
    logic                out_stall;
    stat_t               status;
    id_t                 run_id;
    logic                finished;
    time_t               turnaround;
    time_t               waiting;
    time_t               now;
    logic                all_done;

    // shared between the sender, the receiver and the checker
    sched_res_t pending_results[$];
    dir_row_t   dir_rows[$];
    int         mismatches = 0;
    bit         calm       = 1'b0;   // suppresses idling on both sides
    bit         hold_req   = 1'b0;   // asks the receiver for the long hold-off

    // Shadow copy of the process table, clock and counters. Payload entries
    // are only read once the matching used bit is set.
    logic  sl_used  [N_SLOTS];
    id_t   sl_id    [N_SLOTS];
    time_t sl_arr   [N_SLOTS];
    time_t sl_burst [N_SLOTS];
    time_t sl_left  [N_SLOTS];
    prio_t sl_prio  [N_SLOTS];
    time_t clk_now;
    int    run_slot;
    bit    run_valid;
    int    done_cnt;
    int    used_cnt;

    preemptive_priority_scheduler_core #(
        .SLOTS(N_SLOTS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .proc_id    (proc_id),
        .arrival    (arrival),
        .burst      (burst),
        .prio       (prio),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .run_id     (run_id),
        .finished   (finished),
        .turnaround (turnaround),
        .waiting    (waiting),
        .now        (now),
        .all_done   (all_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic sched_cmd_t mk_cmd(input logic c, input id_t i, input time_t a,
                                          input time_t b, input prio_t p);
        sched_cmd_t x;
        x.cmd     = c;
        x.id      = i;
        x.arrival = a;
        x.burst   = b;
        x.prio    = p;
        return x;
    endfunction

    function automatic sched_res_t mk_res(input stat_t s, input id_t rid,
                                          input logic fin, input time_t tat, input time_t wt,
                                          input time_t nw, input logic ad);
        sched_res_t x;
        x.status     = s;
        x.run_id     = rid;
        x.finished   = fin;
        x.turnaround = tat;
        x.waiting    = wt;
        x.now        = nw;
        x.all_done   = ad;
        return x;
    endfunction

    // Appends one directed row to the stimulus table.
    function automatic void queue_row(input sched_cmd_t c, input logic fx,
                                      input sched_res_t r);
        dir_row_t row;
        row.c         = c;
        row.fixed_exp = fx;
        row.r         = r;
        dir_rows      = {dir_rows, row};
    endfunction

    // Applies one accepted command to the shadow table and returns the
    // result the block must produce for it.
    function automatic sched_res_t predict_schedule(input sched_cmd_t c);
        sched_res_t r;
        bit         placed;
        bit         take;
        int         pick;
        int         i;
        time_t      b;
        time_t      t;
        time_t      w;
        r      = '0;
        placed = 1'b0;
        pick   = -1;
        if (c.cmd == ppsch_pkg::CMD_ADD)
        begin
            // lowest free slot; a zero burst is stored as one unit
            for (i = 0; i < N_SLOTS; i++)
            begin
                if (!placed && !sl_used[i])
                begin
                    b           = (c.burst == '0) ? time_t'(1) : c.burst;
                    sl_used[i]  = 1'b1;
                    sl_id[i]    = c.id;
                    sl_arr[i]   = c.arrival;
                    sl_burst[i] = b;
                    sl_left[i]  = b;
                    sl_prio[i]  = c.prio;
                    used_cnt++;
                    placed = 1'b1;
                end
            end
            r.status = placed ? ppsch_pkg::ST_ADDED : ppsch_pkg::ST_FULL;
        end
        else
        begin
            // priority first, then the running entry, then earliest
            // arrival; the upward scan keeps the lowest slot on a full tie
            for (i = 0; i < N_SLOTS; i++)
            begin
                if (sl_used[i] && sl_left[i] != '0 && sl_arr[i] <= clk_now)
                begin
                    if (pick < 0)
                        take = 1'b1;
                    else if (sl_prio[i] != sl_prio[pick])
                        take = sl_prio[i] < sl_prio[pick];
                    else if (run_valid && run_slot == i)
                        take = 1'b1;
                    else if (run_valid && run_slot == pick)
                        take = 1'b0;
                    else if (sl_arr[i] != sl_arr[pick])
                        take = sl_arr[i] < sl_arr[pick];
                    else
                        take = 1'b0;
                    if (take)
                        pick = i;
                end
            end
            if (pick < 0)
            begin
                r.status = ppsch_pkg::ST_IDLE;
                if (clk_now != ppsch_pkg::TIME_MAX)
                    clk_now++;
            end
            else
            begin
                r.status      = ppsch_pkg::ST_RAN;
                r.run_id      = sl_id[pick];
                sl_left[pick] = sl_left[pick] - time_t'(1);
                if (clk_now != ppsch_pkg::TIME_MAX)
                    clk_now++;
                if (sl_left[pick] == '0)
                begin
                    // differences floor at zero once the clock is pinned
                    t = (clk_now > sl_arr[pick]) ? clk_now - sl_arr[pick] : '0;
                    w = (t > sl_burst[pick]) ? t - sl_burst[pick] : '0;
                    r.finished   = 1'b1;
                    r.turnaround = t;
                    r.waiting    = w;
                    done_cnt++;
                    run_valid = 1'b0;
                    run_slot  = 0;
                end
                else
                begin
                    run_valid = 1'b1;
                    run_slot  = pick;
                end
            end
        end
        r.now      = clk_now;
        r.all_done = (done_cnt == used_cnt);
        return r;
    endfunction

    // Offers one item and holds it until accepted, then books its result.
    task automatic send_item(input sched_cmd_t c, input logic fixed_exp,
                             input sched_res_t fixed_res);
        sched_res_t pred;
        sched_res_t booked;
        in_valid <= 1'b1;
        cmd      <= c.cmd;
        proc_id  <= c.id;
        arrival  <= c.arrival;
        burst    <= c.burst;
        prio     <= c.prio;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred            = predict_schedule(c);
        booked          = fixed_exp ? fixed_res : pred;
        pending_results = {pending_results, booked};
    endtask

    // Occasional random sender gap, skipped in calm stretches.
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] expv,
                               input logic [31:0] gotv);
        if (gotv !== expv)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, expv, gotv);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request so the
    // block backs up and stalls its input while the sender keeps offering.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Checker: every accepted result against the oldest booked expectation.
    always @(posedge clk)
    begin : result_check
        sched_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected, expected none, actual status %0d",
                         $time, status);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("status", 32'(want.status), 32'(status));
                check_field("run_id", 32'(want.run_id), 32'(run_id));
                check_field("finished", 32'(want.finished), 32'(finished));
                check_field("turnaround", 32'(want.turnaround), 32'(turnaround));
                check_field("waiting", 32'(want.waiting), 32'(waiting));
                check_field("now", 32'(want.now), 32'(now));
                check_field("all_done", 32'(want.all_done), 32'(all_done));
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        sched_cmd_t c;
        int         i;
        int         k;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        cmd      <= ppsch_pkg::CMD_ADD;
        proc_id  <= '0;
        arrival  <= '0;
        burst    <= '0;
        prio     <= '0;

        for (i = 0; i < N_SLOTS; i++)
            sl_used[i] = 1'b0;
        clk_now   = '0;
        run_slot  = 0;
        run_valid = 1'b0;
        done_cnt  = 0;
        used_cnt  = 0;

        // Directed rows. Comments give the state the row expects to see.
        // empty table: idle tick, all_done set with nothing added
        queue_row(mk_cmd(ppsch_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0), 1'b1,
                  mk_res(ppsch_pkg::ST_IDLE, 8'd0, 1'b0, 16'd0, 16'd0, 16'd1, 1'b1));
        // zero burst is stored as one, so the next tick completes it
        queue_row(mk_cmd(ppsch_pkg::CMD_ADD, 8'd255, 16'd0, 16'd0, 8'd255), 1'b1,
                  mk_res(ppsch_pkg::ST_ADDED, 8'd0, 1'b0, 16'd0, 16'd0, 16'd1, 1'b0));
        queue_row(mk_cmd(ppsch_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0), 1'b1,
                  mk_res(ppsch_pkg::ST_RAN, 8'd255, 1'b1, 16'd2, 16'd1, 16'd2, 1'b1));
        // top-priority entry arriving at the clock limit; it stays waiting
        // for the whole run
        queue_row(mk_cmd(ppsch_pkg::CMD_ADD, 8'd0, 16'hFFFF, 16'd3, 8'd0), 1'b1,
                  mk_res(ppsch_pkg::ST_ADDED, 8'd0, 1'b0, 16'd0, 16'd0, 16'd2, 1'b0));
        // longest burst at a low priority keeps the table busy in the background
        queue_row(mk_cmd(ppsch_pkg::CMD_ADD, 8'd1, 16'd0, 16'hFFFF, 8'd254), 1'b1,
                  mk_res(ppsch_pkg::ST_ADDED, 8'd0, 1'b0, 16'd0, 16'd0, 16'd2, 1'b0));
        queue_row(mk_cmd(ppsch_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0);
        // arrives exactly now and preempts the background entry
        queue_row(mk_cmd(ppsch_pkg::CMD_ADD, 8'd2, 16'd3, 16'd2, 8'd10), 1'b0, '0);
        queue_row(mk_cmd(ppsch_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0);
        // duplicate id, earlier arrival, same priority: running entry keeps the slot
        queue_row(mk_cmd(ppsch_pkg::CMD_ADD, 8'd2, 16'd0, 16'd2, 8'd10), 1'b0, '0);
        queue_row(mk_cmd(ppsch_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0);
        queue_row(mk_cmd(ppsch_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0);
        queue_row(mk_cmd(ppsch_pkg::CMD_ADD, 8'd3, 16'd0, 16'd1, 8'd10), 1'b0, '0);
        queue_row(mk_cmd(ppsch_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0);
        queue_row(mk_cmd(ppsch_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0);
        // full tie on priority and arrival: lower slot first
        queue_row(mk_cmd(ppsch_pkg::CMD_ADD, 8'd4, 16'd0, 16'd2, 8'd20), 1'b0, '0);
        queue_row(mk_cmd(ppsch_pkg::CMD_ADD, 8'd5, 16'd0, 16'd2, 8'd20), 1'b0, '0);
        queue_row(mk_cmd(ppsch_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0);
        queue_row(mk_cmd(ppsch_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0);
        queue_row(mk_cmd(ppsch_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 8'd0), 1'b0, '0);
        // fill the rest with future arrivals that preempt during the random part;
        // coarse arrival steps and narrow priorities make ties likely
        for (i = 0; i < N_SLOTS - 8; i++)
            queue_row(mk_cmd(ppsch_pkg::CMD_ADD, id_t'($urandom),
                             time_t'(30 + 15 * $urandom_range(0, 40)),
                             time_t'($urandom_range(1, 40)),
                             prio_t'($urandom_range(0, 12))), 1'b0, '0);
        // table full: nothing changes, clock still at eleven
        queue_row(mk_cmd(ppsch_pkg::CMD_ADD, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255), 1'b1,
                  mk_res(ppsch_pkg::ST_FULL, 8'd0, 1'b0, 16'd0, 16'd0, 16'd11, 1'b0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < dir_rows.size(); k++)
        begin
            send_item(dir_rows[k].c, dir_rows[k].fixed_exp, dir_rows[k].r);
            sender_gap();
        end

        // Random part: mostly ticks carrying junk payloads, some adds that
        // bounce off the full table. The future arrivals above drive the
        // preemption and tie-break traffic here.
        for (k = 0; k < RAND_ITEMS; k++)
        begin
            calm = (k >= 600 && k < 700);
            if (k == 250)
                hold_req = 1'b1;
            if (k == 500)
            begin
                // sender pause until the block has drained
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            c = mk_cmd(($urandom_range(0, 99) < 15) ? ppsch_pkg::CMD_ADD : ppsch_pkg::CMD_TICK,
                       id_t'($urandom), time_t'($urandom), time_t'($urandom),
                       prio_t'($urandom));
            send_item(c, 1'b0, '0);
            sender_gap();
        end

        // Last part, no idling: ticks back to back.
        calm = 1'b1;
        for (k = 0; k < N_SLOTS; k++)
            send_item(mk_cmd(ppsch_pkg::CMD_TICK, id_t'($urandom), time_t'($urandom),
                             time_t'($urandom), prio_t'($urandom)), 1'b0, '0);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
